[src/bbm_pkg.sv]
// shared types, constants and view-check function for the breakpoint matcher
`timescale 1ns / 1ps
package bbm_pkg;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // function codes
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_EXEC   = 2'd1;
  localparam logic [1:0] FUNC_ACCESS = 2'd2;

  // entry flag bits
  localparam int unsigned FLG_EN    = 0;
  localparam int unsigned FLG_EXEC  = 1;
  localparam int unsigned FLG_RANGE = 2;
  localparam int unsigned FLG_COUNT = 3;

  // access kind bits
  localparam int unsigned KIND_WRITE = 2;

  // ram view codes
  localparam logic [1:0] RAM_ANY = 2'd0;
  localparam logic [1:0] RAM_AUX = 2'd2;

  // d000 view codes
  localparam logic [1:0] D_ANY = 2'd0;
  localparam logic [1:0] D_ROM = 2'd1;
  localparam logic [1:0] D_LC2 = 2'd3;

  // soft switch bits
  localparam int unsigned MF_ALTZP   = 0;
  localparam int unsigned MF_RAMRD   = 1;
  localparam int unsigned MF_RAMWRT  = 2;
  localparam int unsigned MF_80STORE = 3;
  localparam int unsigned MF_PAGE2   = 4;
  localparam int unsigned MF_HIRES   = 5;
  localparam int unsigned MF_SLOTROM = 6;
  localparam int unsigned MF_LCREAD  = 7;
  localparam int unsigned MF_LCWRITE = 8;
  localparam int unsigned MF_LCBANK2 = 9;

  // memory map
  localparam logic [15:0] ADDR_STACK_END = 16'h0200;
  localparam logic [15:0] ADDR_TEXT_LO   = 16'h0400;
  localparam logic [15:0] ADDR_TEXT_HI   = 16'h0800;
  localparam logic [15:0] ADDR_HGR_LO    = 16'h2000;
  localparam logic [15:0] ADDR_HGR_HI    = 16'h4000;
  localparam logic [15:0] ADDR_IO_LO     = 16'hC000;
  localparam logic [15:0] ADDR_IO_HI     = 16'hC0FF;
  localparam logic [15:0] ADDR_LC_LO     = 16'hD000;
  localparam logic [15:0] ADDR_LC_BANKED = 16'hE000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_DONE
  } state_e;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [4:0]  view;
    logic [2:0]  mask;
    logic [3:0]  flags;
    logic [15:0] start_addr;
    logic [15:0] end_addr;
    cnt_t        limit;
    cnt_t        reload;
    cnt_t        count;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic       matched;
    logic       fired;
    logic [3:0] hit_index;
    logic [3:0] hit_action;
  } result_t;

  function automatic cnt_t to_cnt(logic [15:0] v);
    logic [31:0] w;
    w = {16'b0, v};
    return w[COUNT_BITS-1:0];
  endfunction

  function automatic logic in_aux(logic [15:0] a, logic wr, logic [9:0] s);
    logic aux;
    aux = wr ? s[MF_RAMWRT] : s[MF_RAMRD];
    if (a < ADDR_STACK_END) begin
      aux = s[MF_ALTZP];
    end else if (s[MF_80STORE]) begin
      if (a >= ADDR_TEXT_LO && a < ADDR_TEXT_HI) begin
        aux = s[MF_PAGE2];
      end else if (s[MF_HIRES] && a >= ADDR_HGR_LO && a < ADDR_HGR_HI) begin
        aux = s[MF_PAGE2];
      end
    end
    return aux;
  endfunction

  function automatic logic view_ok(logic [4:0] view, logic [15:0] a, logic wr,
                                   logic [9:0] s);
    logic [1:0] ram;
    logic       slot;
    logic [1:0] d;
    logic       lc_on;
    logic       ok;
    ram   = view[1:0];
    slot  = view[2];
    d     = view[4:3];
    lc_on = wr ? s[MF_LCWRITE] : s[MF_LCREAD];
    if (a >= ADDR_IO_LO && a <= ADDR_IO_HI) begin
      ok = 1'b1;
    end else if (a < ADDR_IO_LO) begin
      ok = (ram == RAM_ANY) || ((ram == RAM_AUX) == in_aux(a, wr, s));
    end else if (a < ADDR_LC_LO) begin
      ok = !slot || s[MF_SLOTROM];
    end else if (d == D_ANY) begin
      ok = 1'b1;
    end else if (!lc_on) begin
      ok = (d == D_ROM);
    end else if (d == D_ROM) begin
      ok = 1'b0;
    end else if (ram != RAM_ANY && ((ram == RAM_AUX) != s[MF_ALTZP])) begin
      ok = 1'b0;
    end else if (a < ADDR_LC_BANKED) begin
      ok = (d == D_LC2) ? s[MF_LCBANK2] : !s[MF_LCBANK2];
    end else begin
      ok = 1'b1;
    end
    return ok;
  endfunction

endpackage

[src/bbm_in_if.sv]
// input channel: load and check beats
`timescale 1ns / 1ps
interface bbm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [3:0]  entry_index;
  logic [15:0] address;
  logic [15:0] end_address;
  logic [2:0]  access_kind;
  logic [3:0]  entry_flags;
  logic [4:0]  view_select;
  logic [15:0] counter_first;
  logic [15:0] counter_reload;
  logic [3:0]  action;
  logic [9:0]  machine_flags;

  modport source (
    output valid, func, entry_index, address, end_address, access_kind,
           entry_flags, view_select, counter_first, counter_reload, action,
           machine_flags,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, address, end_address, access_kind,
           entry_flags, view_select, counter_first, counter_reload, action,
           machine_flags,
    output ready
  );
endinterface

[src/bbm_out_if.sv]
// output channel: match result beats
`timescale 1ns / 1ps
interface bbm_out_if;
  logic       valid;
  logic       ready;
  logic       matched;
  logic       fired;
  logic [3:0] hit_index;
  logic [3:0] hit_action;

  modport source (
    output valid, matched, fired, hit_index, hit_action,
    input  ready
  );
  modport sink (
    input  valid, matched, fired, hit_index, hit_action,
    output ready
  );
endinterface

[src/banked_breakpoint_matcher_unit.sv]
// breakpoint table with sequential entry scan and hit counters
//
// Usage:
//   in_i carries load beats (func 0) that write one table entry and check
//   beats (func 1 exec fetch, func 2 read/write access) that look for the
//   first enabled entry matching access kind, address and bank view.
//   out_o returns exactly one result beat per input beat.
// Sequencing:
//   a load or unused func code goes straight from idle to the done state.
//   A check walks the entry ram one entry per cycle from index 0 and
//   stops at the first match, or after the last entry when nothing
//   matches; a match then passes through a counter write-back state, and
//   every beat ends by loading its result into the output register. No
//   new beat is taken before that, as in_i.ready is high only
//   while the sequencer is idle.
// Reset:
//   all entries read as disabled; no clearing pass is needed.
// Stalls:
//   a result waits in the output register; the next beat is taken while it
//   waits, and a later result holds the sequencer until the register frees.
`timescale 1ns / 1ps
module banked_breakpoint_matcher_unit (
  input  logic clk_i,
  input  logic rst_ni,
  bbm_in_if.sink    in_i,
  bbm_out_if.source out_o
);
  import bbm_pkg::*;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   scan_idx_q, scan_idx_d;
  logic [ENTRIES-1:0] vld_q;
  logic [1:0]         chk_func_q;
  logic [15:0]        chk_addr_q;
  logic [2:0]         chk_kind_q;
  logic [9:0]         chk_mf_q;
  result_t            res_q, res_d;
  result_t            out_q;
  logic               out_valid_q;

  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  entry_t             ram_wdata, ram_rdata;

  logic               in_acc;
  logic               load_ok;
  logic [8:0]         load_idx9;
  logic [8:0]         scan_idx9;
  logic               cur_en, acc_ok, addr_ok, cur_wr, cur_match, last;
  cnt_t               cnt_inc;
  logic               out_load;

  bbm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign load_idx9  = {5'b0, in_i.entry_index};
  assign load_ok    = load_idx9 < 9'(ENTRIES);
  assign scan_idx9  = 9'(scan_idx_q);
  assign last       = (scan_idx_q == IDX_W'(ENTRIES - 1));

  // entry test on the word read for scan_idx_q
  assign cur_en  = vld_q[scan_idx_q] && ram_rdata.flags[FLG_EN];
  assign acc_ok  = (chk_func_q == FUNC_EXEC) ? ram_rdata.flags[FLG_EXEC]
                                             : |(ram_rdata.mask & chk_kind_q);
  assign cur_wr  = (chk_func_q == FUNC_ACCESS) && chk_kind_q[KIND_WRITE];
  assign addr_ok = ram_rdata.flags[FLG_RANGE]
                 ? (chk_addr_q >= ram_rdata.start_addr &&
                    chk_addr_q <= ram_rdata.end_addr)
                 : (chk_addr_q == ram_rdata.start_addr);
  assign cur_match = cur_en && acc_ok && addr_ok &&
                     view_ok(ram_rdata.view, chk_addr_q, cur_wr, chk_mf_q);
  assign cnt_inc   = ram_rdata.count + cnt_t'(1);

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d    = state_q;
    scan_idx_d = scan_idx_q;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_waddr  = scan_idx_q;
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = scan_idx_q + IDX_W'(1);
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_d = '0;
          case (in_i.func)
            FUNC_LOAD: begin
              ram_we               = load_ok;
              ram_waddr            = load_idx9[IDX_W-1:0];
              ram_wdata.action     = in_i.action;
              ram_wdata.view       = in_i.view_select;
              ram_wdata.mask       = in_i.access_kind;
              ram_wdata.flags      = in_i.entry_flags;
              ram_wdata.start_addr = in_i.address;
              ram_wdata.end_addr   = in_i.end_address;
              ram_wdata.limit      = to_cnt(in_i.counter_first);
              ram_wdata.reload     = to_cnt(in_i.counter_reload);
              ram_wdata.count      = '0;
              state_d              = ST_DONE;
            end
            FUNC_EXEC, FUNC_ACCESS: begin
              ram_re     = 1'b1;
              ram_raddr  = '0;
              scan_idx_d = '0;
              state_d    = ST_SCAN;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (cur_match) begin
          res_d.matched   = 1'b1;
          res_d.hit_index = scan_idx9[3:0];
          state_d         = ST_HIT;
        end else if (last) begin
          state_d = ST_DONE;
        end else begin
          ram_re     = 1'b1;
          scan_idx_d = scan_idx_q + IDX_W'(1);
        end
      end
      ST_HIT: begin
        // counter update and write-back of the matched entry
        ram_we  = 1'b1;
        state_d = ST_DONE;
        if (ram_rdata.flags[FLG_COUNT] && (cnt_inc < ram_rdata.limit)) begin
          ram_wdata.count = cnt_inc;
        end else begin
          if (ram_rdata.flags[FLG_COUNT]) begin
            ram_wdata.count = '0;
            ram_wdata.limit = ram_rdata.reload;
          end
          res_d.fired      = 1'b1;
          res_d.hit_action = ram_rdata.action;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc && in_i.func == FUNC_LOAD && load_ok) begin
        vld_q[load_idx9[IDX_W-1:0]] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_idx_q <= scan_idx_d;
    res_q      <= res_d;
    if (in_acc) begin
      chk_func_q <= in_i.func;
      chk_addr_q <= in_i.address;
      chk_kind_q <= in_i.access_kind;
      chk_mf_q   <= in_i.machine_flags;
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.matched    = out_q.matched;
  assign out_o.fired      = out_q.fired;
  assign out_o.hit_index  = out_q.hit_index;
  assign out_o.hit_action = out_q.hit_action;

  a_fired_needs_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.matched || !out_o.fired))
    else $error("fired without a match");

  a_action_needs_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.hit_action != 4'd0) |-> out_o.fired)
    else $error("action code on a result that did not fire");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !ram_we)
    else $error("entry ram written during scan");

  a_check_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.func == FUNC_EXEC || in_i.func == FUNC_ACCESS))
      |=> (state_q == ST_SCAN && scan_idx_q == '0))
    else $error("check beat did not start a scan at entry zero");

  a_hit_is_matched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HIT) |-> res_q.matched)
    else $error("counter update without a recorded match");

endmodule

[src/bbm_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module bbm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

[sim/banked_breakpoint_matcher_unit_test.sv]
// testbench for the breakpoint matcher: random and directed beats checked against a predictor
`timescale 1ns / 1ps
module banked_breakpoint_matcher_unit_test;
  import bbm_pkg::*;

  localparam logic [1:0] FUNC_SPARE = 2'd3;

  localparam logic [3:0] EF_EN    = 4'b0001 << FLG_EN;
  localparam logic [3:0] EF_EXEC  = 4'b0001 << FLG_EXEC;
  localparam logic [3:0] EF_RANGE = 4'b0001 << FLG_RANGE;
  localparam logic [3:0] EF_COUNT = 4'b0001 << FLG_COUNT;

  localparam logic [2:0] ACC_NONE  = 3'b000;
  localparam logic [2:0] ACC_EXEC  = 3'b001;
  localparam logic [2:0] ACC_READ  = 3'b010;
  localparam logic [2:0] ACC_WRITE = 3'b001 << KIND_WRITE;

  localparam logic [1:0] RAM_MAIN     = 2'd1;
  localparam logic [1:0] RAM_ALT_MAIN = 2'd3;

  localparam logic [9:0] SW_NONE    = 10'b0;
  localparam logic [9:0] SW_ALTZP   = 10'b1 << MF_ALTZP;
  localparam logic [9:0] SW_RAMRD   = 10'b1 << MF_RAMRD;
  localparam logic [9:0] SW_LCREAD  = 10'b1 << MF_LCREAD;
  localparam logic [9:0] SW_LCBANK2 = 10'b1 << MF_LCBANK2;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  entry_index;
    logic [15:0] address;
    logic [15:0] end_address;
    logic [2:0]  access_kind;
    logic [3:0]  entry_flags;
    logic [4:0]  view_select;
    logic [15:0] counter_first;
    logic [15:0] counter_reload;
    logic [3:0]  action;
    logic [9:0]  machine_flags;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n;

  bbm_in_if  in_ch ();
  bbm_out_if out_ch ();

  banked_breakpoint_matcher_unit u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  entry_t      bp_table [ENTRIES];
  result_t     pending_results [$];
  result_t     got_result;
  result_t     want_result;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          rx_hold        = 1'b0;
  int unsigned mismatches     = 0;

  function automatic logic aux_selected(logic [15:0] a, logic wr, logic [9:0] sw);
    logic aux;
    if (a < ADDR_STACK_END) begin
      return sw[MF_ALTZP];
    end
    aux = wr ? sw[MF_RAMWRT] : sw[MF_RAMRD];
    if (sw[MF_80STORE]) begin
      if (a >= ADDR_TEXT_LO && a < ADDR_TEXT_HI) begin
        aux = sw[MF_PAGE2];
      end else if (sw[MF_HIRES] && a >= ADDR_HGR_LO && a < ADDR_HGR_HI) begin
        aux = sw[MF_PAGE2];
      end
    end
    return aux;
  endfunction

  function automatic logic bank_agrees(logic [4:0] v, logic [15:0] a, logic wr,
                                       logic [9:0] sw);
    logic [1:0] ram;
    logic [1:0] dsel;
    logic       lc_on;
    ram  = v[1:0];
    dsel = v[4:3];
    if (a >= ADDR_IO_LO && a <= ADDR_IO_HI) begin
      return 1'b1;
    end
    if (a < ADDR_IO_LO) begin
      return (ram == RAM_ANY) || ((ram == RAM_AUX) == aux_selected(a, wr, sw));
    end
    if (a < ADDR_LC_LO) begin
      return !v[2] || sw[MF_SLOTROM];
    end
    if (dsel == D_ANY) begin
      return 1'b1;
    end
    lc_on = wr ? sw[MF_LCWRITE] : sw[MF_LCREAD];
    if (!lc_on) begin
      return dsel == D_ROM;
    end
    if (dsel == D_ROM) begin
      return 1'b0;
    end
    if (ram != RAM_ANY && ((ram == RAM_AUX) != sw[MF_ALTZP])) begin
      return 1'b0;
    end
    if (a < ADDR_LC_BANKED) begin
      return (dsel == D_LC2) == sw[MF_LCBANK2];
    end
    return 1'b1;
  endfunction

  function automatic result_t predict_outcome(beat_t b);
    result_t    r;
    logic       wr;
    logic       hit;
    logic [3:0] fl;
    r = '0;
    if (b.func == FUNC_LOAD) begin
      if (int'(b.entry_index) < ENTRIES) begin
        bp_table[b.entry_index].flags      = b.entry_flags;
        bp_table[b.entry_index].mask       = b.access_kind;
        bp_table[b.entry_index].view       = b.view_select;
        bp_table[b.entry_index].action     = b.action;
        bp_table[b.entry_index].start_addr = b.address;
        bp_table[b.entry_index].end_addr   = b.end_address;
        bp_table[b.entry_index].count      = '0;
        bp_table[b.entry_index].limit      = cnt_t'(b.counter_first);
        bp_table[b.entry_index].reload     = cnt_t'(b.counter_reload);
      end
      return r;
    end
    if (b.func != FUNC_EXEC && b.func != FUNC_ACCESS) begin
      return r;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (!r.matched) begin
        fl  = bp_table[i].flags;
        hit = fl[FLG_EN];
        if (b.func == FUNC_EXEC) begin
          hit = hit && fl[FLG_EXEC];
          wr  = 1'b0;
        end else begin
          hit = hit && ((bp_table[i].mask & b.access_kind) != 3'b0);
          wr  = b.access_kind[KIND_WRITE];
        end
        if (fl[FLG_RANGE]) begin
          hit = hit && b.address >= bp_table[i].start_addr
                    && b.address <= bp_table[i].end_addr;
        end else begin
          hit = hit && b.address == bp_table[i].start_addr;
        end
        hit = hit && bank_agrees(bp_table[i].view, b.address, wr, b.machine_flags);
        if (hit) begin
          r.matched   = 1'b1;
          r.hit_index = 4'(i);
          if (fl[FLG_COUNT]) begin
            bp_table[i].count = bp_table[i].count + 1'b1;
            if (bp_table[i].count >= bp_table[i].limit) begin
              bp_table[i].limit = bp_table[i].reload;
              bp_table[i].count = '0;
              r.fired           = 1'b1;
            end
          end else begin
            r.fired = 1'b1;
          end
          if (r.fired) begin
            r.hit_action = bp_table[i].action;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] region_addr();
    case ($urandom_range(0, 8))
      0: return 16'($urandom_range(ADDR_STACK_END - 1, 0));
      1: return 16'($urandom_range(ADDR_TEXT_HI - 1, ADDR_TEXT_LO));
      2: return 16'($urandom_range(ADDR_HGR_HI - 1, ADDR_HGR_LO));
      3: return 16'($urandom_range(ADDR_IO_HI, ADDR_IO_LO));
      4: return 16'($urandom_range(ADDR_LC_LO - 1, ADDR_IO_HI + 1));
      5: return 16'($urandom_range(ADDR_LC_BANKED - 1, ADDR_LC_LO));
      6: return 16'($urandom_range(16'hFFFF, ADDR_LC_BANKED));
      7: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic beat_t make_load(logic [3:0] idx, logic [3:0] flags, logic [2:0] mask,
                                      logic [15:0] first_addr, logic [15:0] last_addr,
                                      logic [4:0] view, logic [15:0] first_cnt,
                                      logic [15:0] reload_cnt, logic [3:0] act);
    beat_t b;
    b = {$urandom, $urandom, $urandom};
    b.func           = FUNC_LOAD;
    b.entry_index    = idx;
    b.entry_flags    = flags;
    b.access_kind    = mask;
    b.address        = first_addr;
    b.end_address    = last_addr;
    b.view_select    = view;
    b.counter_first  = first_cnt;
    b.counter_reload = reload_cnt;
    b.action         = act;
    return b;
  endfunction

  function automatic beat_t make_check(logic [1:0] fn, logic [15:0] a, logic [2:0] kind,
                                       logic [9:0] sw);
    beat_t b;
    b = {$urandom, $urandom, $urandom};
    b.func          = fn;
    b.address       = a;
    b.access_kind   = kind;
    b.machine_flags = sw;
    return b;
  endfunction

  function automatic beat_t random_beat();
    beat_t       b;
    int unsigned k;
    int unsigned pick;
    b    = {$urandom, $urandom, $urandom};
    pick = $urandom_range(0, 99);
    k    = $urandom_range(0, ENTRIES - 1);
    if (pick < 12) begin
      b.func        = FUNC_LOAD;
      b.entry_flags = {($urandom_range(0, 9) < 3), 1'($urandom), 1'($urandom),
                       ($urandom_range(0, 9) < 8)};
      b.address     = region_addr();
      if ($urandom_range(0, 9) < 7) begin
        b.end_address = b.address + 16'($urandom_range(0, 511));
      end
      if ($urandom_range(0, 99) < 85) begin
        b.counter_first  = 16'($urandom_range(0, 3));
        b.counter_reload = 16'($urandom_range(0, 3));
      end
    end else if (pick < 15) begin
      b.func = FUNC_SPARE;
    end else begin
      b.func = $urandom_range(0, 1) ? FUNC_EXEC : FUNC_ACCESS;
      if (bp_table[k].flags[FLG_EN] && $urandom_range(0, 3) != 0) begin
        if (bp_table[k].flags[FLG_RANGE] &&
            bp_table[k].start_addr <= bp_table[k].end_addr) begin
          b.address = 16'($urandom_range(bp_table[k].end_addr, bp_table[k].start_addr));
        end else begin
          b.address = bp_table[k].start_addr;
        end
      end else begin
        b.address = region_addr();
      end
    end
    return b;
  endfunction

  task automatic send_beat(input beat_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.func           <= b.func;
    in_ch.entry_index    <= b.entry_index;
    in_ch.address        <= b.address;
    in_ch.end_address    <= b.end_address;
    in_ch.access_kind    <= b.access_kind;
    in_ch.entry_flags    <= b.entry_flags;
    in_ch.view_select    <= b.view_select;
    in_ch.counter_first  <= b.counter_first;
    in_ch.counter_reload <= b.counter_reload;
    in_ch.action         <= b.action;
    in_ch.machine_flags  <= b.machine_flags;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    pending_results.push_back(predict_outcome(b));
  endtask

  // result side: random stalls, long hold-off on request, compare in order
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
      if (out_ch.valid && out_ch.ready) begin
        got_result = {out_ch.matched, out_ch.fired, out_ch.hit_index, out_ch.hit_action};
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, got m=%0b f=%0b idx=%0d act=%0d",
                   $time, got_result.matched, got_result.fired, got_result.hit_index,
                   got_result.hit_action);
          mismatches++;
        end else begin
          want_result = pending_results.pop_front();
          if (got_result !== want_result) begin
            $display("%0t: expected m=%0b f=%0b idx=%0d act=%0d, got m=%0b f=%0b idx=%0d act=%0d",
                     $time, want_result.matched, want_result.fired, want_result.hit_index,
                     want_result.hit_action, got_result.matched, got_result.fired,
                     got_result.hit_index, got_result.hit_action);
            mismatches++;
          end
        end
      end
    end
  end

  // every entry written once, left disabled
  task automatic test_table_fill();
    for (int i = 0; i < ENTRIES; i++) begin
      send_beat(make_load(4'(i), 4'($urandom) & ~EF_EN, 3'($urandom), 16'($urandom),
                          16'($urandom), 5'($urandom), 16'($urandom), 16'($urandom),
                          4'($urandom)));
    end
  endtask

  task automatic test_directed();
    send_beat(make_check(FUNC_EXEC, 16'h0000, ACC_EXEC, SW_NONE));
    // exact exec match at the top address
    send_beat(make_load(4'd0, EF_EN | EF_EXEC, ACC_NONE, 16'hFFFF, 16'h0000,
                        {D_ANY, 1'b0, RAM_ANY}, 16'h0000, 16'h0000, 4'hF));
    send_beat(make_check(FUNC_EXEC, 16'hFFFF, ACC_EXEC, SW_NONE));
    send_beat(make_check(FUNC_ACCESS, 16'hFFFF, ACC_READ, SW_NONE));
    // full range write watch, ram view three acts as main
    send_beat(make_load(4'd15, EF_EN | EF_RANGE, ACC_WRITE, 16'h0000, 16'hFFFF,
                        {D_LC2, 1'b1, RAM_ALT_MAIN}, 16'hFFFF, 16'hFFFF, 4'h5));
    send_beat(make_check(FUNC_ACCESS, 16'h0300, ACC_READ | ACC_WRITE, SW_RAMRD));
    send_beat(make_check(FUNC_ACCESS, ADDR_IO_LO + 16'h0050, ACC_WRITE, SW_NONE));
    send_beat(make_check(FUNC_ACCESS, ADDR_IO_HI + 16'h0001, ACC_WRITE, SW_NONE));
    // hit counter with limits zero and one
    send_beat(make_load(4'd3, EF_EN | EF_EXEC | EF_COUNT, ACC_NONE, 16'h1234, 16'h1234,
                        {D_ANY, 1'b0, RAM_ANY}, 16'h0000, 16'h0001, 4'h9));
    repeat (2) send_beat(make_check(FUNC_EXEC, 16'h1234, ACC_EXEC, SW_NONE));
    send_beat(make_load(4'd3, EF_EN | EF_EXEC | EF_COUNT, ACC_NONE, 16'h1234, 16'h1234,
                        {D_ANY, 1'b0, RAM_MAIN}, 16'h0003, 16'hFFFF, 4'h9));
    repeat (4) send_beat(make_check(FUNC_EXEC, 16'h1234, ACC_EXEC, SW_NONE));
    // reversed range
    send_beat(make_load(4'd4, EF_EN | EF_EXEC | EF_RANGE, ACC_EXEC, 16'h8000, 16'h7000,
                        {D_ANY, 1'b0, RAM_ANY}, 16'h0000, 16'h0000, 4'h1));
    send_beat(make_check(FUNC_EXEC, 16'h7800, ACC_EXEC, SW_NONE));
    send_beat(make_check(FUNC_SPARE, 16'h1234, ACC_EXEC, SW_NONE));
    // language card bank 2 in aux
    send_beat(make_load(4'd5, EF_EN, ACC_EXEC | ACC_READ | ACC_WRITE, 16'hD123, 16'h0000,
                        {D_LC2, 1'b0, RAM_AUX}, 16'h0000, 16'h0000, 4'hA));
    send_beat(make_check(FUNC_ACCESS, 16'hD123, ACC_READ, SW_LCREAD | SW_ALTZP | SW_LCBANK2));
    send_beat(make_check(FUNC_ACCESS, 16'hD123, ACC_READ, SW_ALTZP | SW_LCBANK2));
    send_beat(make_check(FUNC_ACCESS, 16'h0100, ACC_WRITE, SW_ALTZP));
    send_beat(make_check(FUNC_ACCESS, 16'h0000, ACC_NONE, SW_NONE));
  endtask

  task automatic test_traffic(input int unsigned beats, input int unsigned idle_pct,
                              input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (beats) send_beat(random_beat());
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (250) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (16) send_beat(random_beat());
  endtask

  task automatic test_drain_pause();
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    repeat (15) send_beat(random_beat());
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (15) send_beat(random_beat());
  endtask

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.func           = FUNC_LOAD;
    in_ch.entry_index    = '0;
    in_ch.address        = '0;
    in_ch.end_address    = '0;
    in_ch.access_kind    = '0;
    in_ch.entry_flags    = '0;
    in_ch.view_select    = '0;
    in_ch.counter_first  = '0;
    in_ch.counter_reload = '0;
    in_ch.action         = '0;
    in_ch.machine_flags  = '0;
    foreach (bp_table[k]) begin
      bp_table[k] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_table_fill();
    test_directed();
    test_traffic(95, 0, 0);
    test_traffic(95, 69, 0);
    test_traffic(95, 0, 69);
    test_traffic(95, 34, 34);
    test_backpressure();
    test_drain_pause();

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[filelist.f]
src/bbm_pkg.sv
src/bbm_in_if.sv
src/bbm_out_if.sv
src/bbm_ram.sv
src/banked_breakpoint_matcher_unit.sv
sim/banked_breakpoint_matcher_unit_test.sv
